FILE: src/chm_pkg.sv
// Shared types, constants and control encodings for the coalesced hash map.
// Used by chm_ctrl, chm_dp and the coalesced_hash_map top level.
`default_nettype none
package chm_pkg;

   localparam int MAX_LOG2     = 10;
   localparam int INIT_LOG2    = 1;
   localparam int PROBE_STRIDE = 47;
   localparam int SLOT_AW      = MAX_LOG2;
   localparam int SLOTS        = 1 << MAX_LOG2;
   localparam int LINK_W       = MAX_LOG2 + 2;
   localparam int COUNT_W      = MAX_LOG2 + 1;
   localparam int LOG2_W       = 4;

   localparam logic [LINK_W-1:0]  LINK_END  = LINK_W'(2) << MAX_LOG2;
   localparam logic [LINK_W-1:0]  LINK_MARK = LINK_W'(1) << MAX_LOG2;
   localparam logic [LOG2_W-1:0]  LOG2_MAX  = LOG2_W'(MAX_LOG2);
   localparam logic [LOG2_W-1:0]  LOG2_INIT =
      LOG2_W'((INIT_LOG2 < MAX_LOG2) ? INIT_LOG2 : MAX_LOG2);
   localparam logic [SLOT_AW-1:0] STRIDE    = SLOT_AW'(PROBE_STRIDE);

   localparam logic [1:0] OP_PUT      = 2'd0;
   localparam logic [1:0] OP_PUT_KEEP = 2'd1;
   localparam logic [1:0] OP_GET      = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [31:0]        old_value;
      logic               status;
      logic [COUNT_W-1:0] entry_count;
      logic [LOG2_W-1:0]  size_log2;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_WALK, ST_PROBE, ST_PLACE, ST_LINK, ST_FIN, ST_DONE,
      ST_G_CLR, ST_P1_RD, ST_P1_CHK, ST_P1_MV, ST_P1_NX,
      ST_P2_RD, ST_P2_CHK, ST_P2_LOOP, ST_P2_J, ST_P2_SWI, ST_P2_CLRI,
      ST_P2_W, ST_P2_WE, ST_P2_NX
   } state_type;

   typedef enum logic [2:0] {PTR_HOLD, PTR_HOME, PTR_LINK, PTR_STEP, PTR_AHASH} ptr_sel_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_type;
   typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC} i_op_type;
   typedef enum logic [1:0] {WA_PTR, WA_TAIL, WA_I, WA_IN} waddr_type;
   typedef enum logic [1:0] {WS_REQ, WS_RD, WS_A} wsrc_type;
   typedef enum logic [1:0] {LK_END, LK_MARK, LK_PTR, LK_I} link_sel_type;

   typedef struct packed {
      logic         req_load;
      ptr_sel_type  ptr_sel;
      logic         wide_mask;
      logic         rd_i;
      cnt_op_type   cnt_op;
      i_op_type     i_op;
      logic         tail_load;
      logic         a_load;
      logic         we_used;
      logic         used_val;
      logic         we_data;
      logic         we_link;
      waddr_type    waddr;
      wsrc_type     wsrc;
      link_sel_type link_sel;
      logic         count_inc;
      logic         log2_inc;
      logic         res_clr;
      logic         set_found;
      logic         set_reject;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic rd_used;
      logic key_hit;
      logic link_end;
      logic link_mark;
      logic cnt_last;
      logic cnt_full;
      logic i_last;
      logic home_old;
      logic home_new;
      logic a_home;
      logic op_ins;
      logic op_put;
      logic grow_need;
   } stat_type;

endpackage
`default_nettype wire

FILE: src/chm_dp.sv
// Datapath: slot memories, index registers, request and result registers.
// Driven by chm_ctrl through chm_pkg::cmd_type; depends on chm_pkg.
`default_nettype none
module chm_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire chm_pkg::req_type req_item,
   input  wire chm_pkg::cmd_type cmd,
   output chm_pkg::stat_type     stat,
   output chm_pkg::rsp_type      rsp_item
);

   logic                         mem_used [chm_pkg::SLOTS];
   logic [31:0]                  mem_key  [chm_pkg::SLOTS];
   logic [31:0]                  mem_hash [chm_pkg::SLOTS];
   logic [31:0]                  mem_val  [chm_pkg::SLOTS];
   logic [chm_pkg::LINK_W-1:0]   mem_link [chm_pkg::SLOTS];

   logic                         rd_used_ff;
   logic [31:0]                  rd_key_ff, rd_hash_ff, rd_val_ff;
   logic [chm_pkg::LINK_W-1:0]   rd_link_ff;

   chm_pkg::req_type             req_ff;
   logic [31:0]                  a_key_ff, a_hash_ff, a_val_ff;
   logic [chm_pkg::SLOT_AW-1:0]  ptr_ff, ptr_in, tail_ff, i_ff;
   logic [chm_pkg::COUNT_W-1:0]  cnt_ff, count_ff;
   logic [chm_pkg::LOG2_W-1:0]   log2_ff;
   logic                         found_ff, status_ff;
   logic [31:0]                  old_ff;

   logic [chm_pkg::SLOT_AW-1:0]  mask, nmask, msk, raddr, waddr;
   logic [chm_pkg::COUNT_W-1:0]  size;
   logic [chm_pkg::COUNT_W+1:0]  load3, size2;
   logic [31:0]                  wkey, whash, wval;
   logic [chm_pkg::LINK_W-1:0]   wlink;

   assign mask  = ~({chm_pkg::SLOT_AW{1'b1}} << log2_ff);
   assign nmask = ~({chm_pkg::SLOT_AW{1'b1}} << (log2_ff + chm_pkg::LOG2_W'(1)));
   assign msk   = cmd.wide_mask ? nmask : mask;
   assign size  = chm_pkg::COUNT_W'(1) << log2_ff;
   assign load3 = {1'b0, count_ff, 1'b0} + {2'b00, count_ff};
   assign size2 = (chm_pkg::COUNT_W+2)'(1) << (log2_ff + chm_pkg::LOG2_W'(1));

   always_comb begin
      case (cmd.ptr_sel)
         chm_pkg::PTR_HOME:  ptr_in = req_item.key_hash[chm_pkg::SLOT_AW-1:0] & mask;
         chm_pkg::PTR_LINK:  ptr_in = rd_link_ff[chm_pkg::SLOT_AW-1:0] & msk;
         chm_pkg::PTR_STEP:  ptr_in = (ptr_ff + chm_pkg::STRIDE) & mask;
         chm_pkg::PTR_AHASH: ptr_in = a_hash_ff[chm_pkg::SLOT_AW-1:0] & nmask;
         default:            ptr_in = ptr_ff;
      endcase
   end

   assign raddr = cmd.rd_i ? i_ff : ptr_in;

   always_comb begin
      case (cmd.waddr)
         chm_pkg::WA_TAIL: waddr = tail_ff;
         chm_pkg::WA_I:    waddr = i_ff;
         chm_pkg::WA_IN:   waddr = i_ff | size[chm_pkg::SLOT_AW-1:0];
         default:          waddr = ptr_ff;
      endcase
      case (cmd.wsrc)
         chm_pkg::WS_RD: begin
            wkey = rd_key_ff; whash = rd_hash_ff; wval = rd_val_ff;
         end
         chm_pkg::WS_A: begin
            wkey = a_key_ff; whash = a_hash_ff; wval = a_val_ff;
         end
         default: begin
            wkey = req_ff.key; whash = req_ff.key_hash; wval = req_ff.value;
         end
      endcase
      case (cmd.link_sel)
         chm_pkg::LK_MARK: wlink = chm_pkg::LINK_MARK;
         chm_pkg::LK_PTR:  wlink = {2'b00, ptr_ff};
         chm_pkg::LK_I:    wlink = {2'b00, i_ff};
         default:          wlink = chm_pkg::LINK_END;
      endcase
   end

   // slot storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.we_used) begin
         mem_used[waddr] <= cmd.used_val;
      end
      if (cmd.we_data) begin
         mem_key[waddr]  <= wkey;
         mem_hash[waddr] <= whash;
         mem_val[waddr]  <= wval;
      end
      if (cmd.we_link) begin
         mem_link[waddr] <= wlink;
      end
      rd_used_ff <= mem_used[raddr];
      rd_key_ff  <= mem_key[raddr];
      rd_hash_ff <= mem_hash[raddr];
      rd_val_ff  <= mem_val[raddr];
      rd_link_ff <= mem_link[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_item;
      end
      if (cmd.a_load) begin
         a_key_ff  <= rd_key_ff;
         a_hash_ff <= rd_hash_ff;
         a_val_ff  <= rd_val_ff;
      end
      if (cmd.tail_load) begin
         tail_ff <= ptr_ff;
      end
      ptr_ff <= ptr_in;
      if (cmd.set_found) begin
         old_ff <= rd_val_ff;
      end else if (cmd.res_clr) begin
         old_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         cnt_ff    <= '0;
         count_ff  <= '0;
         log2_ff   <= chm_pkg::LOG2_INIT;
         found_ff  <= 1'b0;
         status_ff <= chm_pkg::STATUS_OK;
      end else begin
         case (cmd.i_op)
            chm_pkg::I_CLR: i_ff <= '0;
            chm_pkg::I_INC: i_ff <= i_ff + chm_pkg::SLOT_AW'(1);
            default:        i_ff <= i_ff;
         endcase
         case (cmd.cnt_op)
            chm_pkg::CNT_CLR: cnt_ff <= '0;
            chm_pkg::CNT_INC: cnt_ff <= cnt_ff + chm_pkg::COUNT_W'(1);
            default:          cnt_ff <= cnt_ff;
         endcase
         if (cmd.count_inc) begin
            count_ff <= count_ff + chm_pkg::COUNT_W'(1);
         end
         if (cmd.log2_inc) begin
            log2_ff <= log2_ff + chm_pkg::LOG2_W'(1);
         end
         if (cmd.res_clr) begin
            found_ff  <= 1'b0;
            status_ff <= chm_pkg::STATUS_OK;
         end else begin
            if (cmd.set_found) begin
               found_ff <= 1'b1;
            end
            if (cmd.set_reject) begin
               status_ff <= chm_pkg::STATUS_FULL;
            end
         end
      end
   end

   always_comb begin
      stat.rd_used   = rd_used_ff;
      stat.key_hit   = (rd_hash_ff == req_ff.key_hash) && (rd_key_ff == req_ff.key);
      stat.link_end  = (rd_link_ff == chm_pkg::LINK_END);
      stat.link_mark = (rd_link_ff == chm_pkg::LINK_MARK);
      stat.cnt_last  = ((cnt_ff + chm_pkg::COUNT_W'(1)) == size);
      stat.cnt_full  = (cnt_ff == chm_pkg::COUNT_W'(size << 1));
      stat.i_last    = (i_ff == mask);
      stat.home_old  = ((rd_hash_ff[chm_pkg::SLOT_AW-1:0] & mask) == i_ff);
      stat.home_new  = ((rd_hash_ff[chm_pkg::SLOT_AW-1:0] & nmask) == i_ff);
      stat.a_home    = ((a_hash_ff[chm_pkg::SLOT_AW-1:0] & nmask) == i_ff);
      stat.op_ins    = (req_ff.operation == chm_pkg::OP_PUT) ||
                       (req_ff.operation == chm_pkg::OP_PUT_KEEP);
      stat.op_put    = (req_ff.operation == chm_pkg::OP_PUT);
      stat.grow_need = (log2_ff < chm_pkg::LOG2_MAX) && (load3 > size2);
   end

   always_comb begin
      rsp_item.found       = found_ff;
      rsp_item.old_value   = old_ff;
      rsp_item.status      = status_ff;
      rsp_item.entry_count = count_ff;
      rsp_item.size_log2   = log2_ff;
   end

endmodule
`default_nettype wire

FILE: src/chm_ctrl.sv
// Control state machine: chain walk, probe, insert and two-pass doubling.
// Drives chm_dp with chm_pkg::cmd_type; depends on chm_pkg.
`default_nettype none
module chm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire chm_pkg::stat_type stat,
   output chm_pkg::cmd_type       cmd
);

   chm_pkg::state_type state_ff, state_in;
   logic               tail_ff, tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chm_pkg::ST_INIT;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      tail_in  = tail_ff;
      cmd      = '0;
      busy     = (state_ff != chm_pkg::ST_IDLE);
      case (state_ff)
         chm_pkg::ST_INIT: begin
            cmd.we_used = 1'b1;
            cmd.waddr   = chm_pkg::WA_I;
            if (stat.i_last) begin
               cmd.i_op = chm_pkg::I_CLR;
               state_in = chm_pkg::ST_IDLE;
            end else begin
               cmd.i_op = chm_pkg::I_INC;
            end
         end
         chm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               cmd.ptr_sel  = chm_pkg::PTR_HOME;
               cmd.cnt_op   = chm_pkg::CNT_CLR;
               cmd.res_clr  = 1'b1;
               tail_in      = 1'b0;
               state_in     = chm_pkg::ST_WALK;
            end
         end
         chm_pkg::ST_WALK: begin
            if (!stat.rd_used) begin
               state_in = stat.op_ins ? chm_pkg::ST_PLACE : chm_pkg::ST_FIN;
            end else if (stat.key_hit) begin
               cmd.set_found = 1'b1;
               if (stat.op_put) begin
                  cmd.we_data = 1'b1;
                  cmd.waddr   = chm_pkg::WA_PTR;
                  cmd.wsrc    = chm_pkg::WS_REQ;
               end
               state_in = chm_pkg::ST_FIN;
            end else if (stat.link_end || stat.cnt_last) begin
               cmd.tail_load = 1'b1;
               tail_in       = 1'b1;
               if (stat.op_ins) begin
                  cmd.ptr_sel = chm_pkg::PTR_STEP;
                  cmd.cnt_op  = chm_pkg::CNT_CLR;
                  state_in    = chm_pkg::ST_PROBE;
               end else begin
                  state_in = chm_pkg::ST_FIN;
               end
            end else begin
               cmd.ptr_sel = chm_pkg::PTR_LINK;
               cmd.cnt_op  = chm_pkg::CNT_INC;
            end
         end
         chm_pkg::ST_PROBE: begin
            if (!stat.rd_used) begin
               state_in = chm_pkg::ST_PLACE;
            end else if (stat.cnt_last) begin
               cmd.set_reject = 1'b1;
               state_in       = chm_pkg::ST_FIN;
            end else begin
               cmd.ptr_sel = chm_pkg::PTR_STEP;
               cmd.cnt_op  = chm_pkg::CNT_INC;
            end
         end
         chm_pkg::ST_PLACE: begin
            cmd.we_used   = 1'b1;
            cmd.used_val  = 1'b1;
            cmd.we_data   = 1'b1;
            cmd.we_link   = 1'b1;
            cmd.waddr     = chm_pkg::WA_PTR;
            cmd.wsrc      = chm_pkg::WS_REQ;
            cmd.link_sel  = chm_pkg::LK_END;
            cmd.count_inc = 1'b1;
            state_in      = tail_ff ? chm_pkg::ST_LINK : chm_pkg::ST_FIN;
         end
         chm_pkg::ST_LINK: begin
            cmd.we_link  = 1'b1;
            cmd.waddr    = chm_pkg::WA_TAIL;
            cmd.link_sel = chm_pkg::LK_PTR;
            state_in     = chm_pkg::ST_FIN;
         end
         chm_pkg::ST_FIN: begin
            if (stat.op_ins && stat.grow_need) begin
               cmd.i_op = chm_pkg::I_CLR;
               state_in = chm_pkg::ST_G_CLR;
            end else begin
               state_in = chm_pkg::ST_DONE;
            end
         end
         chm_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = chm_pkg::ST_IDLE;
         end
         // doubling: clear the upper half
         chm_pkg::ST_G_CLR: begin
            cmd.we_used = 1'b1;
            cmd.waddr   = chm_pkg::WA_IN;
            if (stat.i_last) begin
               cmd.i_op = chm_pkg::I_CLR;
               state_in = chm_pkg::ST_P1_RD;
            end else begin
               cmd.i_op = chm_pkg::I_INC;
            end
         end
         // first pass: home keys stay or move up, others get marked
         chm_pkg::ST_P1_RD: begin
            cmd.rd_i = 1'b1;
            state_in = chm_pkg::ST_P1_CHK;
         end
         chm_pkg::ST_P1_CHK: begin
            state_in = chm_pkg::ST_P1_NX;
            if (stat.rd_used) begin
               cmd.we_link = 1'b1;
               if (stat.home_old && stat.home_new) begin
                  cmd.waddr    = chm_pkg::WA_I;
                  cmd.link_sel = chm_pkg::LK_END;
               end else if (stat.home_old) begin
                  cmd.we_used  = 1'b1;
                  cmd.used_val = 1'b1;
                  cmd.we_data  = 1'b1;
                  cmd.waddr    = chm_pkg::WA_IN;
                  cmd.wsrc     = chm_pkg::WS_RD;
                  cmd.link_sel = chm_pkg::LK_END;
                  state_in     = chm_pkg::ST_P1_MV;
               end else begin
                  cmd.waddr    = chm_pkg::WA_I;
                  cmd.link_sel = chm_pkg::LK_MARK;
               end
            end
         end
         chm_pkg::ST_P1_MV: begin
            cmd.we_used = 1'b1;
            cmd.waddr   = chm_pkg::WA_I;
            state_in    = chm_pkg::ST_P1_NX;
         end
         chm_pkg::ST_P1_NX: begin
            if (stat.i_last) begin
               cmd.i_op = chm_pkg::I_CLR;
               state_in = chm_pkg::ST_P2_RD;
            end else begin
               cmd.i_op = chm_pkg::I_INC;
               state_in = chm_pkg::ST_P1_RD;
            end
         end
         // second pass: place marked keys
         chm_pkg::ST_P2_RD: begin
            cmd.rd_i = 1'b1;
            state_in = chm_pkg::ST_P2_CHK;
         end
         chm_pkg::ST_P2_CHK: begin
            if (stat.rd_used && stat.link_mark) begin
               cmd.a_load = 1'b1;
               state_in   = chm_pkg::ST_P2_LOOP;
            end else begin
               state_in = chm_pkg::ST_P2_NX;
            end
         end
         chm_pkg::ST_P2_LOOP: begin
            if (stat.a_home) begin
               cmd.we_link  = 1'b1;
               cmd.waddr    = chm_pkg::WA_I;
               cmd.link_sel = chm_pkg::LK_END;
               state_in     = chm_pkg::ST_P2_NX;
            end else begin
               cmd.ptr_sel = chm_pkg::PTR_AHASH;
               cmd.cnt_op  = chm_pkg::CNT_CLR;
               state_in    = chm_pkg::ST_P2_J;
            end
         end
         chm_pkg::ST_P2_J: begin
            if (!stat.rd_used || stat.link_mark) begin
               cmd.we_used  = 1'b1;
               cmd.used_val = 1'b1;
               cmd.we_data  = 1'b1;
               cmd.we_link  = 1'b1;
               cmd.waddr    = chm_pkg::WA_PTR;
               cmd.wsrc     = chm_pkg::WS_A;
               cmd.link_sel = chm_pkg::LK_END;
               if (!stat.rd_used) begin
                  state_in = chm_pkg::ST_P2_CLRI;
               end else begin
                  // swap: the displaced marked key becomes the one to place
                  cmd.a_load = 1'b1;
                  state_in   = chm_pkg::ST_P2_SWI;
               end
            end else if (stat.link_end) begin
               cmd.we_link  = 1'b1;
               cmd.waddr    = chm_pkg::WA_PTR;
               cmd.link_sel = chm_pkg::LK_I;
               state_in     = chm_pkg::ST_P2_WE;
            end else begin
               cmd.ptr_sel   = chm_pkg::PTR_LINK;
               cmd.wide_mask = 1'b1;
               cmd.cnt_op    = chm_pkg::CNT_INC;
               state_in      = chm_pkg::ST_P2_W;
            end
         end
         chm_pkg::ST_P2_SWI: begin
            cmd.we_used  = 1'b1;
            cmd.used_val = 1'b1;
            cmd.we_data  = 1'b1;
            cmd.we_link  = 1'b1;
            cmd.waddr    = chm_pkg::WA_I;
            cmd.wsrc     = chm_pkg::WS_A;
            cmd.link_sel = chm_pkg::LK_MARK;
            state_in     = chm_pkg::ST_P2_LOOP;
         end
         chm_pkg::ST_P2_CLRI: begin
            cmd.we_used = 1'b1;
            cmd.waddr   = chm_pkg::WA_I;
            state_in    = chm_pkg::ST_P2_NX;
         end
         chm_pkg::ST_P2_W: begin
            if (stat.link_end || stat.cnt_full) begin
               cmd.we_link  = 1'b1;
               cmd.waddr    = chm_pkg::WA_PTR;
               cmd.link_sel = chm_pkg::LK_I;
               state_in     = chm_pkg::ST_P2_WE;
            end else begin
               cmd.ptr_sel   = chm_pkg::PTR_LINK;
               cmd.wide_mask = 1'b1;
               cmd.cnt_op    = chm_pkg::CNT_INC;
            end
         end
         chm_pkg::ST_P2_WE: begin
            cmd.we_link  = 1'b1;
            cmd.waddr    = chm_pkg::WA_I;
            cmd.link_sel = chm_pkg::LK_END;
            state_in     = chm_pkg::ST_P2_NX;
         end
         chm_pkg::ST_P2_NX: begin
            if (stat.i_last) begin
               cmd.i_op     = chm_pkg::I_CLR;
               cmd.log2_inc = 1'b1;
               state_in     = chm_pkg::ST_DONE;
            end else begin
               cmd.i_op = chm_pkg::I_INC;
               state_in = chm_pkg::ST_P2_RD;
            end
         end
         default: begin
            state_in = chm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/coalesced_hash_map.sv
// Top level of the coalesced-chaining key/value map.
// Instantiates chm_ctrl and chm_dp; depends on chm_pkg.
//
// Usage:
//  - Request channel: drive req_item (operation, key, key_hash, value) and
//    raise start; the request is taken at a clock edge where start is high
//    and busy is low. busy stays high until the response has been issued.
//  - Response channel: rsp_valid is high for exactly one cycle with
//    rsp_item (found, old_value, status, entry_count, size_log2). The
//    receiver has no way to stall it and must take it in that cycle.
//  - One request at a time. A lookup, or any request whose chain ends at its
//    home slot without an insert, reads its home slot and then passes through
//    the finish and response states before the next request can be taken.
//    Each further chain link walked adds a slot read. A new key is written in
//    a place state; behind a chain tail it first probes by the stride (at
//    least one step) and then links the tail. The chain walk and probe share
//    one registered read port of the slot memories, one slot per cycle.
//  - A doubling (after an insert pushes the load above 2/3, below the
//    size bound) adds a sweep over the old size n: a clear of the upper
//    half, then a first pass and a second pass over each slot (chain walks
//    and swaps in the second pass add steps).
//  - Reset: synchronous, active high. After reset busy stays high for a
//    clearing pass over the initial table, then the map is empty with
//    size_log2 at its initial value.
//  - Table full at the size bound: a new key is rejected with status 1.
`default_nettype none
module coalesced_hash_map (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire chm_pkg::req_type req_item,
   output logic                  rsp_valid,
   output chm_pkg::rsp_type      rsp_item
);

   chm_pkg::cmd_type  cmd;
   chm_pkg::stat_type stat;

   chm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   chm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

   // strobe comes from the controller's response state
   assign rsp_valid = cmd.emit;

endmodule
`default_nettype wire
